### src/mlrq_pkg.sv
// ----------------------------------------------------------------------------
// mlrq_pkg: shared types for the multilevel ready queue scheduler
// Command codes, sequencer states and the queue operation bundle.
// ----------------------------------------------------------------------------
package mlrq_pkg;

  localparam int unsigned IdW  = 6;
  localparam int unsigned LvlW = 2;
  localparam int unsigned QntW = 8;
  localparam int unsigned CntW = 32;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_SCHED  = 3'd2,
    CMD_YIELD  = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_POP,
    ST_SWITCH,
    ST_DONE
  } state_e;

  // one operation applied to every cell of a queue
  typedef struct packed {
    logic           push;
    logic           pop;
    logic           rm;
    logic [IdW-1:0] id;
  } qop_t;

endpackage

### src/mlrq_ram.sv
// ----------------------------------------------------------------------------
// mlrq_ram: generic single write, single read RAM
// Read data is registered and held while the read enable is low.
// ----------------------------------------------------------------------------
module mlrq_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/mlrq_cell.sv
// ----------------------------------------------------------------------------
// mlrq_cell: one slot of a ready queue
// Holds one task id; takes its right neighbor's id on a dequeue or when a
// removal match has been seen at or before this slot.
// ----------------------------------------------------------------------------
module mlrq_cell (
  input  logic                    clk_i,
  input  mlrq_pkg::qop_t          op_i,
  input  logic                    valid_i,
  input  logic                    tail_i,
  input  logic [mlrq_pkg::IdW-1:0] next_id_i,
  input  logic                    seen_i,
  output logic [mlrq_pkg::IdW-1:0] id_o,
  output logic                    seen_o
);

  logic [mlrq_pkg::IdW-1:0] id_q, id_d;
  logic                     match;

  // first-match chain for removal
  assign match  = op_i.rm & valid_i & (id_q == op_i.id);
  assign seen_o = seen_i | match;

  always_comb begin
    id_d = id_q;
    if (op_i.pop) begin
      id_d = next_id_i;
    end else if (op_i.push && tail_i) begin
      id_d = op_i.id;
    end else if (seen_o) begin
      id_d = next_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign id_o = id_q;

endmodule

### src/mlrq_queue.sv
// ----------------------------------------------------------------------------
// mlrq_queue: one FIFO ready queue built as a row of cells
// Head sits in cell 0; dequeue and removal shift the row toward the head.
// ----------------------------------------------------------------------------
module mlrq_queue #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mlrq_pkg::qop_t           op_i,
  output logic [mlrq_pkg::IdW-1:0] head_o,
  output logic                     empty_o,
  output logic                     full_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]            count_q, count_d;
  logic [mlrq_pkg::IdW-1:0] ids [DEPTH];
  logic [DEPTH:0]           seen;
  logic                     found;

  assign seen[0] = 1'b0;
  assign found   = seen[DEPTH];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign head_o  = ids[0];

  // row of cells
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [mlrq_pkg::IdW-1:0] next_id;
    if (k == DEPTH - 1) begin : g_last
      assign next_id = '0;
    end else begin : g_mid
      assign next_id = ids[k+1];
    end
    mlrq_cell u_cell (
      .clk_i     (clk_i),
      .op_i      (op_i),
      .valid_i   (CW'(k) < count_q),
      .tail_i    (CW'(k) == count_q),
      .next_id_i (next_id),
      .seen_i    (seen[k]),
      .id_o      (ids[k]),
      .seen_o    (seen[k+1])
    );
  end

  // fill level
  always_comb begin
    count_d = count_q;
    if (op_i.push && !full_o) begin
      count_d = count_q + CW'(1);
    end else if (op_i.pop && !empty_o) begin
      count_d = count_q - CW'(1);
    end else if (op_i.rm && found) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

### src/multilevel_ready_queue_scheduler_top.sv
// ----------------------------------------------------------------------------
// multilevel_ready_queue_scheduler_top: priority ready queue task scheduler
// Commands add, remove, schedule, yield and tick over several FIFO levels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command per transfer:
//   cmd_i, task_id_i, level_i. Every command gives exactly one result on the
//   output channel (out_valid_o/out_ready_i): running task, event flags,
//   remaining quantum and the three wrapping statistics counters.
//   Config channel (cfg_valid_i/cfg_ready_o) writes the quantum; a zero
//   write is ignored. Write it only while no command is in flight.
// Sequencing:
//   A command runs through decode, queue pop and switch steps of a small
//   sequencer; the level memory is read when it is taken, and each step makes
//   a single queue access. Add, remove and ticks that leave quantum go from
//   decode to the result; schedule, yield and quantum-ending ticks pass the
//   pop step, and the switch step on a context switch. One command is in flight at a time.
//   A removal searches its whole queue in one step through the cell chain.
// Reset:
//   All queues empty, no task running, quantum 10, counters zero.
// Stall:
//   The result is held in an output register; while it waits the sequencer
//   holds the next result and accepts no further command.
// ----------------------------------------------------------------------------
module multilevel_ready_queue_scheduler_top #(
  parameter int unsigned NUM_TASKS   = 64,
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned NUM_LEVELS  = 3
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [mlrq_pkg::QntW-1:0] cfg_quantum_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                cmd_i,
  input  logic [mlrq_pkg::IdW-1:0]  task_id_i,
  input  logic [mlrq_pkg::LvlW-1:0] level_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [mlrq_pkg::IdW-1:0]  running_id_o,
  output logic                      switched_o,
  output logic                      went_idle_o,
  output logic [mlrq_pkg::QntW-1:0] ticks_left_o,
  output logic                      queue_full_error_o,
  output logic [mlrq_pkg::CntW-1:0] switch_count_o,
  output logic [mlrq_pkg::CntW-1:0] call_count_o,
  output logic [mlrq_pkg::CntW-1:0] idle_count_o
);

  localparam int unsigned TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned IW = mlrq_pkg::IdW;
  localparam int unsigned QW = mlrq_pkg::QntW;
  localparam int unsigned NW = mlrq_pkg::CntW;
  localparam int unsigned LW = mlrq_pkg::LvlW;

  mlrq_pkg::state_e state_q, state_d;

  logic [2:0]    cmd_q;
  logic [IW-1:0] id_q;
  logic [LW-1:0] lvl_q;
  logic [IW-1:0] cur_q, cur_d;
  logic [IW-1:0] next_q, next_d;
  logic          push_old_q, push_old_d;
  logic [QW-1:0] ql_q, ql_d;
  logic [QW-1:0] quantum_q;
  logic [NUM_TASKS-1:0] run_q;
  logic [NW-1:0] sw_cnt_q, sw_cnt_d, call_cnt_q, call_cnt_d, idle_cnt_q, idle_cnt_d;
  logic          f_sw_q, f_sw_d, f_idle_q, f_idle_d, f_err_q, f_err_d;

  logic          out_valid_q;
  logic [IW-1:0] o_run_q;
  logic [QW-1:0] o_ql_q;
  logic          o_sw_q, o_idle_q, o_err_q;
  logic [NW-1:0] o_swc_q, o_callc_q, o_idlec_q;

  logic          in_xfer, out_load;
  logic          id_ok, cur_run;

  // level memory
  logic          lm_we, lm_re;
  logic [TW-1:0] lm_raddr;
  logic [LW-1:0] lm_rdata;

  // queue control
  logic          push_en, pop_en, rm_en;
  logic [LW-1:0] push_lvl, rm_lvl;
  logic [IW-1:0] push_id;
  logic          run_clr_en, run_set_en;
  logic [IW-1:0] run_clr_id, run_set_id;

  logic [IW-1:0] head   [NUM_LEVELS];
  logic          empty  [NUM_LEVELS];
  logic          full   [NUM_LEVELS];
  logic          any_ready, push_full;
  logic [IW-1:0] pop_id;
  logic [LW-1:0] pop_lvl;

  assign in_ready_o  = (state_q == mlrq_pkg::ST_IDLE);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign id_ok       = (id_q != '0) && (int'(id_q) < NUM_TASKS);
  assign cur_run     = run_q[TW'(cur_q)];

  // level of the command's task on remove, else of the running task
  assign lm_re    = in_xfer;
  assign lm_raddr = (cmd_i == mlrq_pkg::CMD_REMOVE) ? TW'(task_id_i) : TW'(cur_q);
  assign lm_we    = (state_q == mlrq_pkg::ST_DECODE) && (cmd_q == mlrq_pkg::CMD_ADD) &&
                    id_ok && (int'(lvl_q) < NUM_LEVELS);

  mlrq_ram #(
    .WIDTH (LW),
    .DEPTH (NUM_TASKS)
  ) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (lm_we),
    .waddr_i (TW'(id_q)),
    .wdata_i (lvl_q),
    .re_i    (lm_re),
    .raddr_i (lm_raddr),
    .rdata_o (lm_rdata)
  );

  // ready queues
  for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_level
    mlrq_pkg::qop_t op;
    assign op.push = push_en && (int'(push_lvl) == l);
    assign op.pop  = pop_en && (int'(pop_lvl) == l);
    assign op.rm   = rm_en && (int'(rm_lvl) == l);
    assign op.id   = rm_en ? id_q : push_id;
    mlrq_queue #(
      .DEPTH (QUEUE_DEPTH)
    ) u_queue (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (op),
      .head_o  (head[l]),
      .empty_o (empty[l]),
      .full_o  (full[l])
    );
  end

  // first non-empty level counting from level 0, and full check of the push target
  always_comb begin
    any_ready = 1'b0;
    pop_id    = '0;
    pop_lvl   = '0;
    push_full = 1'b0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (!empty[l]) begin
        any_ready = 1'b1;
        pop_id    = head[l];
        pop_lvl   = LW'(l);
      end
      if (int'(push_lvl) == l && full[l]) begin
        push_full = 1'b1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    next_d     = next_q;
    push_old_d = push_old_q;
    ql_d       = ql_q;
    sw_cnt_d   = sw_cnt_q;
    call_cnt_d = call_cnt_q;
    idle_cnt_d = idle_cnt_q;
    f_sw_d     = f_sw_q;
    f_idle_d   = f_idle_q;
    f_err_d    = f_err_q;
    push_en    = 1'b0;
    push_lvl   = lm_rdata;
    push_id    = cur_q;
    pop_en     = 1'b0;
    rm_en      = 1'b0;
    rm_lvl     = lm_rdata;
    run_clr_en = 1'b0;
    run_clr_id = cur_q;
    run_set_en = 1'b0;
    run_set_id = next_q;
    out_load   = 1'b0;
    case (state_q)
      mlrq_pkg::ST_IDLE: begin
        if (in_xfer) begin
          f_sw_d   = 1'b0;
          f_idle_d = 1'b0;
          f_err_d  = 1'b0;
          state_d  = mlrq_pkg::ST_DECODE;
        end
      end
      mlrq_pkg::ST_DECODE: begin
        state_d = mlrq_pkg::ST_DONE;
        case (cmd_q)
          mlrq_pkg::CMD_ADD: begin
            if (id_ok && (int'(lvl_q) < NUM_LEVELS)) begin
              push_en    = 1'b1;
              push_lvl   = lvl_q;
              push_id    = id_q;
              run_clr_en = 1'b1;
              run_clr_id = id_q;
            end
          end
          mlrq_pkg::CMD_REMOVE: begin
            rm_en = id_ok;
          end
          mlrq_pkg::CMD_SCHED: begin
            state_d = mlrq_pkg::ST_POP;
          end
          mlrq_pkg::CMD_YIELD: begin
            if (cur_q != '0) begin
              push_en    = 1'b1;
              run_clr_en = 1'b1;
            end
            state_d = mlrq_pkg::ST_POP;
          end
          mlrq_pkg::CMD_TICK: begin
            if (cur_q != '0) begin
              if (ql_q != '0) begin
                ql_d = ql_q - QW'(1);
              end
              // quantum used up: yield
              if (ql_q <= QW'(1)) begin
                push_en    = 1'b1;
                run_clr_en = 1'b1;
                state_d    = mlrq_pkg::ST_POP;
              end
            end
          end
          default: begin
          end
        endcase
        if (push_en && push_full) begin
          f_err_d = 1'b1;
        end
      end
      mlrq_pkg::ST_POP: begin
        call_cnt_d = call_cnt_q + NW'(1);
        state_d    = mlrq_pkg::ST_DONE;
        if (!any_ready) begin
          idle_cnt_d = idle_cnt_q + NW'(1);
          f_idle_d   = 1'b1;
        end else begin
          pop_en = 1'b1;
          if (pop_id != cur_q) begin
            sw_cnt_d   = sw_cnt_q + NW'(1);
            f_sw_d     = 1'b1;
            next_d     = pop_id;
            push_old_d = (cur_q != '0) && cur_run;
            state_d    = mlrq_pkg::ST_SWITCH;
          end
        end
      end
      mlrq_pkg::ST_SWITCH: begin
        // old task back to its level, new task in
        if (push_old_q) begin
          push_en    = 1'b1;
          run_clr_en = 1'b1;
          if (push_full) begin
            f_err_d = 1'b1;
          end
        end
        run_set_en = 1'b1;
        cur_d      = next_q;
        ql_d       = quantum_q;
        state_d    = mlrq_pkg::ST_DONE;
      end
      mlrq_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = mlrq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mlrq_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlrq_pkg::ST_IDLE;
      cur_q       <= '0;
      ql_q        <= '0;
      quantum_q   <= QW'(10);
      run_q       <= '0;
      sw_cnt_q    <= '0;
      call_cnt_q  <= '0;
      idle_cnt_q  <= '0;
      push_old_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      ql_q       <= ql_d;
      sw_cnt_q   <= sw_cnt_d;
      call_cnt_q <= call_cnt_d;
      idle_cnt_q <= idle_cnt_d;
      push_old_q <= push_old_d;
      if (cfg_valid_i && (cfg_quantum_i != '0)) begin
        quantum_q <= cfg_quantum_i;
      end
      if (run_clr_en) begin
        run_q[TW'(run_clr_id)] <= 1'b0;
      end
      if (run_set_en) begin
        run_q[TW'(run_set_id)] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk_i) begin
    f_sw_q   <= f_sw_d;
    f_idle_q <= f_idle_d;
    f_err_q  <= f_err_d;
    next_q   <= next_d;
    if (in_xfer) begin
      cmd_q <= cmd_i;
      id_q  <= task_id_i;
      lvl_q <= level_i;
    end
    if (out_load) begin
      o_run_q   <= cur_q;
      o_ql_q    <= ql_q;
      o_sw_q    <= f_sw_q;
      o_idle_q  <= f_idle_q;
      o_err_q   <= f_err_q;
      o_swc_q   <= sw_cnt_q;
      o_callc_q <= call_cnt_q;
      o_idlec_q <= idle_cnt_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign running_id_o       = o_run_q;
  assign switched_o         = o_sw_q;
  assign went_idle_o        = o_idle_q;
  assign ticks_left_o       = o_ql_q;
  assign queue_full_error_o = o_err_q;
  assign switch_count_o     = o_swc_q;
  assign call_count_o       = o_callc_q;
  assign idle_count_o       = o_idlec_q;

endmodule

### test/multilevel_ready_queue_scheduler_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multilevel_ready_queue_scheduler_top_test: self-checking scheduler bench
// Drives add, remove, schedule, yield and tick commands, with quantum writes
// between phases. Every result is checked against an in-bench scheduler
// model under random idling on both channels.
// ----------------------------------------------------------------------------
module multilevel_ready_queue_scheduler_top_test;

  localparam int NTASK  = 64;
  localparam int QDEPTH = 64;
  localparam int NLVL   = 3;
  localparam int LIMIT  = 400000;
  localparam int IW     = mlrq_pkg::IdW;
  localparam int LW     = mlrq_pkg::LvlW;
  localparam int QW     = mlrq_pkg::QntW;
  localparam int NW     = mlrq_pkg::CntW;

  typedef struct packed {
    logic [IW-1:0] running_id;
    logic          switched;
    logic          went_idle;
    logic [QW-1:0] ticks_left;
    logic          queue_full_error;
    logic [NW-1:0] switch_count;
    logic [NW-1:0] call_count;
    logic [NW-1:0] idle_count;
  } sched_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [QW-1:0] cfg_quantum_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] cmd_i = '0;
  logic [IW-1:0] task_id_i = '0;
  logic [LW-1:0] level_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  sched_res_t res_got;

  multilevel_ready_queue_scheduler_top u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_quantum_i,
    .in_valid_i, .in_ready_o, .cmd_i, .task_id_i, .level_i,
    .out_valid_o, .out_ready_i,
    .running_id_o(res_got.running_id), .switched_o(res_got.switched),
    .went_idle_o(res_got.went_idle), .ticks_left_o(res_got.ticks_left),
    .queue_full_error_o(res_got.queue_full_error),
    .switch_count_o(res_got.switch_count), .call_count_o(res_got.call_count),
    .idle_count_o(res_got.idle_count)
  );

  initial forever #2 clk_i = ~clk_i;

  // scheduler model state
  logic [IW-1:0] mq [NLVL][$];
  logic [LW-1:0] m_level [NTASK];
  bit            m_run [NTASK];
  logic [IW-1:0] m_cur;
  logic [QW-1:0] m_qleft, m_quantum;
  logic [NW-1:0] m_sw, m_calls, m_idle;
  bit f_sw, f_idle, f_full;

  sched_res_t expected_q[$];
  int errors = 0, n_results = 0, n_items = 0, cycles = 0;
  int send_idle_pct = 0, recv_stall_pct = 0, hold_off = 0;
  bit [NTASK-1:0] added;

  function automatic void model_push(int lvl, logic [IW-1:0] id);
    if (mq[lvl].size() >= QDEPTH) f_full = 1;
    else mq[lvl].push_back(id);
  endfunction

  function automatic void model_requeue(logic [IW-1:0] id);
    if (id == 0) return;
    m_run[id] = 0;
    model_push(m_level[id], id);
  endfunction

  function automatic void model_schedule();
    logic [IW-1:0] nxt = 0;
    m_calls++;
    for (int l = 0; l < NLVL; l++)
      if (mq[l].size() != 0) begin
        nxt = mq[l].pop_front();
        break;
      end
    if (nxt == 0) begin
      m_idle++;
      f_idle = 1;
      return;
    end
    if (m_cur != 0 && m_cur == nxt) return;
    m_sw++;
    f_sw = 1;
    if (m_cur != 0 && m_run[m_cur]) model_requeue(m_cur);
    m_run[nxt] = 1;
    m_cur = nxt;
    m_qleft = m_quantum;
  endfunction

  function automatic void model_yield();
    if (m_cur != 0) model_requeue(m_cur);
    model_schedule();
  endfunction

  function automatic sched_res_t predict_command(logic [2:0] c, logic [IW-1:0] id,
                                                 logic [LW-1:0] lv);
    sched_res_t r;
    f_sw = 0; f_idle = 0; f_full = 0;
    case (c)
      mlrq_pkg::CMD_ADD: if (id != 0 && lv < NLVL) begin
        m_level[id] = lv;
        m_run[id] = 0;
        model_push(lv, id);
      end
      mlrq_pkg::CMD_REMOVE: if (id != 0) begin
        int l = m_level[id];
        foreach (mq[l][k])
          if (mq[l][k] == id) begin
            mq[l].delete(k);
            break;
          end
      end
      mlrq_pkg::CMD_SCHED: model_schedule();
      mlrq_pkg::CMD_YIELD: model_yield();
      mlrq_pkg::CMD_TICK: if (m_cur != 0) begin
        if (m_qleft > 0) m_qleft--;
        if (m_qleft == 0) model_yield();
      end
      default: ;
    endcase
    r = '{m_cur, f_sw, f_idle, m_qleft, f_full, m_sw, m_calls, m_idle};
    return r;
  endfunction

  // drive one command; prediction at the transfer edge
  task automatic send_command(logic [2:0] c, logic [IW-1:0] id, logic [LW-1:0] lv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= c;
    task_id_i <= id;
    level_i <= lv;
    do @(posedge clk_i); while (!in_ready_o);
    if (c == mlrq_pkg::CMD_ADD && id != 0 && lv < NLVL) added[id] = 1;
    expected_q.push_back(predict_command(c, id, lv));
    n_items++;
    @(negedge clk_i);
  endtask

  // wait for drain, then write the quantum
  task automatic write_quantum(logic [QW-1:0] q);
    in_valid_i <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (8) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_quantum_i <= q;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (q != 0) m_quantum = q;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver stall pattern and optional long hold-off
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    sched_res_t e;
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t timeout", $time);
      $display("TB_ERROR");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %p", $time, res_got);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (res_got !== e) begin
          $display("%0t mismatch exp %p got %p", $time, e, res_got);
          errors++;
        end
      end
    end
  end

  function automatic logic [IW-1:0] known_id();
    logic [IW-1:0] id;
    do id = IW'($urandom_range(1, NTASK - 1)); while (!added[id]);
    return id;
  endfunction

  task automatic test_directed();
    send_command(mlrq_pkg::CMD_SCHED, 0, 0);        // idle schedule
    send_command(mlrq_pkg::CMD_TICK, 0, 0);         // tick with nothing running
    send_command(mlrq_pkg::CMD_YIELD, 0, 0);
    send_command(mlrq_pkg::CMD_ADD, 0, 1);          // id zero ignored
    send_command(mlrq_pkg::CMD_ADD, 5, 3);          // bad level ignored
    send_command(mlrq_pkg::CMD_ADD, 63, 2);
    send_command(mlrq_pkg::CMD_ADD, 1, 0);
    send_command(mlrq_pkg::CMD_ADD, 1, 0);          // duplicate copy
    send_command(mlrq_pkg::CMD_ADD, 42, 1);
    send_command(mlrq_pkg::CMD_SCHED, 0, 0);
    send_command(mlrq_pkg::CMD_SCHED, 0, 0);        // head equals current
    send_command(mlrq_pkg::CMD_REMOVE, 42, 1);
    send_command(mlrq_pkg::CMD_REMOVE, 42, 1);      // absent
    send_command(mlrq_pkg::CMD_REMOVE, 0, 0);
    send_command(3'd5, 7, 1);
    send_command(3'd7, 63, 3);
    send_command(mlrq_pkg::CMD_YIELD, 0, 0);
    repeat (4) send_command(mlrq_pkg::CMD_TICK, 0, 0);
    send_command(mlrq_pkg::CMD_SCHED, 0, 0);
  endtask

  task automatic test_queue_full();
    for (int i = 0; i < QDEPTH + 2; i++)
      send_command(mlrq_pkg::CMD_ADD, IW'((i % 62) + 2), 2);
    repeat (QDEPTH + 4) send_command(mlrq_pkg::CMD_SCHED, 0, 0);
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 35)
        send_command(mlrq_pkg::CMD_ADD, IW'($urandom), LW'($urandom_range(0, 2)));
      else if (r < 45)
        send_command(mlrq_pkg::CMD_REMOVE, added != 0 ? known_id() : IW'(0), LW'($urandom));
      else if (r < 60) send_command(mlrq_pkg::CMD_SCHED, IW'($urandom), LW'($urandom));
      else if (r < 70) send_command(mlrq_pkg::CMD_YIELD, IW'($urandom), LW'($urandom));
      else if (r < 95) send_command(mlrq_pkg::CMD_TICK, IW'($urandom), LW'($urandom));
      else send_command(3'($urandom_range(5, 7)), IW'($urandom), LW'($urandom));
    end
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    repeat (20) send_command(mlrq_pkg::CMD_TICK, 0, 0);
  endtask

  initial begin
    m_cur = 0; m_qleft = 0; m_quantum = 10; m_sw = 0; m_calls = 0; m_idle = 0;
    added = '0;
    foreach (m_run[i]) begin
      m_run[i] = 0;
      m_level[i] = 0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_queue_full();
    write_quantum(1);
    test_random(150);
    write_quantum(0);                      // ignored
    send_idle_pct = 68;
    test_random(150);
    write_quantum(255);
    send_idle_pct = 0; recv_stall_pct = 68;
    test_random(150);
    write_quantum(3);
    send_idle_pct = 35; recv_stall_pct = 35;
    test_random(200);
    test_backpressure();
    send_idle_pct = 0; recv_stall_pct = 0;
    write_quantum(10);
    test_random(100);
    in_valid_i <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("Ran %0d commands, %0d results checked, over five quantum settings", n_items,
             n_results);
    $display("with idle, stall and long hold-off phases; %0d errors", errors);
    if (errors == 0 && expected_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
